/* sv/bdhr_pkg.sv */
// ----------------------------------------------------------------------------
// bdhr_pkg - shared types and constants for the button debouncer
// Event codes, register indexes, counter width and the lane config struct.
// ----------------------------------------------------------------------------
package bdhr_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int EV_W        = 3;
  localparam int CNT_W       = 12;  // signed, spans -255..1024
  localparam int DEB_W       = 8;
  localparam int HOLD_W      = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [EV_W-1:0] EV_NONE         = 3'd0;
  localparam logic [EV_W-1:0] EV_PRESS        = 3'd1;
  localparam logic [EV_W-1:0] EV_RELEASE      = 3'd2;
  localparam logic [EV_W-1:0] EV_HOLDING      = 3'd3;
  localparam logic [EV_W-1:0] EV_HOLD_RELEASE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd2;

  localparam logic [DEB_W-1:0]       DEBOUNCE_RST = 8'd20;
  localparam logic [HOLD_W-1:0]      HOLD_RST     = 10'd500;
  localparam logic [NUM_BUTTONS-1:0] REPEAT_RST   = 4'd3;

  typedef logic [EV_W-1:0] event_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HOLD_W-1:0] hold_ticks;
  } timing_cfg_t;

endpackage

/* sv/bdhr_lane.sv */
// ----------------------------------------------------------------------------
// bdhr_lane - per-button debounce / hold counter
// One signed counter per button, stepped once for every accepted word.
// ----------------------------------------------------------------------------
module bdhr_lane import bdhr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        pressed,
  input  logic        repeat_en,
  input  timing_cfg_t cfg,
  output event_t      ev
);

  logic signed [CNT_W-1:0] press_counter;
  logic signed [CNT_W-1:0] press_counter_next;
  logic signed [CNT_W-1:0] deb;
  logic signed [CNT_W-1:0] hold;
  logic signed [CNT_W-1:0] cnt_inc;

  assign deb     = signed'({{(CNT_W-DEB_W){1'b0}}, cfg.debounce_ticks});
  assign hold    = signed'({{(CNT_W-HOLD_W){1'b0}}, cfg.hold_ticks});
  assign cnt_inc = press_counter + CNT_W'(1);

  // phases tested in order: idle, press debounce, pressed, hold edge,
  // holding, release debounce
  always_comb begin
    ev                 = EV_NONE;
    press_counter_next = press_counter;
    priority if (press_counter == CNT_W'(0)) begin
      if (pressed) begin
        ev                 = EV_PRESS;
        press_counter_next = CNT_W'(1);
      end
    end else if (press_counter > CNT_W'(0) && press_counter < deb) begin
      press_counter_next = cnt_inc;
    end else if (press_counter >= deb && press_counter < hold) begin
      if (!pressed) begin
        ev                 = EV_RELEASE;
        press_counter_next = -deb;
      end else begin
        press_counter_next = cnt_inc;
      end
    end else if (press_counter == hold) begin
      press_counter_next = cnt_inc;
    end else if (press_counter > hold) begin
      if (pressed) begin
        if (repeat_en) begin
          ev = EV_HOLDING;
        end
      end else begin
        ev                 = EV_HOLD_RELEASE;
        press_counter_next = -deb;
      end
    end else begin
      press_counter_next = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_counter <= '0;
    end else if (step) begin
      press_counter <= press_counter_next;
    end
  end

endmodule

/* sv/bdhr_merge.sv */
// ----------------------------------------------------------------------------
// bdhr_merge - result word register
// Gathers the lane events into one result word and holds it for the sink.
// ----------------------------------------------------------------------------
module bdhr_merge import bdhr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  event_t lane_ev [NUM_BUTTONS],
  input  logic   out_ready,
  output logic   out_valid,
  output logic   slot_free,
  output event_t word_ev [NUM_BUTTONS]
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_ev <= lane_ev;
    end
  end

endmodule

/* sv/button_debounce_hold_repeat.sv */
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat - four-button debouncer with hold repeat
// Each word is one scan tick of active-low pins; each result word carries
// one event code per button (none, press, release, holding, hold release).
// ----------------------------------------------------------------------------
//
//  channel  handshake                 payload
//  -------  ------------------------  ------------------------------------
//  in       in_valid / in_ready       pins_n[3:0]
//  out      out_valid / out_ready     event_b0 .. event_b3 [2:0]
//  cfg      cfg_we (no back-pressure) cfg_index[1:0], cfg_data[9:0]
//
//  One tick word per cycle. Every lane updates its counter at the edge the
//  word is accepted, and the events land in the result register at that
//  same edge, so the result word is offered from the next cycle.
//  in_ready is high while the result register is empty or being drained,
//  so a stalled sink holds one finished word and stops intake only then.
//  rst (synchronous) idles all buttons and loads the default timings.
//
module button_debounce_hold_repeat import bdhr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // tick words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NUM_BUTTONS-1:0] pins_n,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [EV_W-1:0]       event_b0,
  output logic [EV_W-1:0]       event_b1,
  output logic [EV_W-1:0]       event_b2,
  output logic [EV_W-1:0]       event_b3,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  timing_cfg_t            timing;
  logic [NUM_BUTTONS-1:0] repeat_mask;
  logic                   accept;
  logic                   slot_free;
  event_t                 lane_ev [NUM_BUTTONS];
  event_t                 word_ev [NUM_BUTTONS];

  // --- configuration registers; indexes beyond the list are ignored ---
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.debounce_ticks <= DEBOUNCE_RST;
      timing.hold_ticks     <= HOLD_RST;
      repeat_mask           <= REPEAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: timing.debounce_ticks <= cfg_data[DEB_W-1:0];
        REG_HOLD:     timing.hold_ticks     <= cfg_data[HOLD_W-1:0];
        REG_REPEAT:   repeat_mask           <= cfg_data[NUM_BUTTONS-1:0];
        default:      ;
      endcase
    end
  end

  // a tick is taken whenever the result slot can take its word
  assign in_ready = slot_free;
  assign accept   = in_valid && slot_free;

  // --- one lane per button, all stepped by the same tick ---
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bdhr_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .step      (accept),
      .pressed   (!pins_n[i]),
      .repeat_en (repeat_mask[i]),
      .cfg       (timing),
      .ev        (lane_ev[i])
    );
  end

  // --- gather the lane events into the result word ---
  bdhr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .lane_ev   (lane_ev),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .word_ev   (word_ev)
  );

  assign event_b0 = word_ev[0];
  assign event_b1 = word_ev[1];
  assign event_b2 = word_ev[2];
  assign event_b3 = word_ev[3];

endmodule
